### hdl/assert_macros.svh
// Assertion helpers used by the filter RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vslpf_pkg.sv
`default_nettype none

package vslpf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;

  localparam int ALPHA_W = FRAC_BITS + 1;
  localparam int DVS_W   = CFG_W + 1;
  localparam int REM_W   = CFG_W + 2;
  localparam int ACC_W   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DIFF_W  = ACC_W + 1;
  localparam int PROD_W  = DIFF_W + 1 + ALPHA_W;
  localparam int PART_W  = PROD_W - FRAC_BITS;
  localparam int CNT_W   = $clog2(ALPHA_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] TIME_CONST_RST = CFG_W'(500);
  localparam logic [CFG_W-1:0] GAP_LIMIT_RST  = CFG_W'(6000);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [TIME_WIDTH-1:0]          stamp;
  } vslpf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           restarted;
  } vslpf_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } vslpf_stat_t;

endpackage

`default_nettype wire

### hdl/vslpf_div.sv
`default_nettype none

module vslpf_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [vslpf_pkg::CFG_W-1:0]   dividend_i,
  input  wire  [vslpf_pkg::DVS_W-1:0]   divisor_i,
  output vslpf_pkg::vslpf_stat_t        stat_o,
  output logic [vslpf_pkg::ALPHA_W-1:0] quot_o
);
  import vslpf_pkg::*;

  logic [REM_W-1:0]   rem_q, rem_d;
  logic [DVS_W-1:0]   dvs_q;
  logic [ALPHA_W-1:0] quot_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic               ge;
  logic [REM_W-1:0]   diff;

  // One quotient bit per cycle; the remainder always stays below twice the divisor.
  assign ge    = rem_q >= REM_W'(dvs_q);
  assign diff  = ge ? (rem_q - REM_W'(dvs_q)) : rem_q;
  assign rem_d = {diff[REM_W-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ALPHA_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(dividend_i);
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[ALPHA_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

### hdl/vslpf_mul.sv
`default_nettype none

module vslpf_mul (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [vslpf_pkg::DIFF_W-1:0]  mcand_i,
  input  wire  [vslpf_pkg::ALPHA_W-1:0] mplier_i,
  output vslpf_pkg::vslpf_stat_t        stat_o,
  output logic [vslpf_pkg::PROD_W-1:0]  prod_o
);
  import vslpf_pkg::*;

  logic [DIFF_W:0]    hi_q;
  logic [ALPHA_W-1:0] lo_q;
  logic [DIFF_W-1:0]  mc_q;
  logic [ALPHA_W-1:0] mp_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [DIFF_W:0]    addend;
  logic [DIFF_W:0]    sum;

  // Signed multiplicand times unsigned multiplier, one multiplier bit per cycle,
  // least significant bit first, with the partial sum shifted right each step.
  assign addend = mp_q[0] ? {mc_q[DIFF_W-1], mc_q} : '0;
  assign sum    = hi_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ALPHA_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      mc_q <= mcand_i;
      mp_q <= mplier_i;
    end else if (busy_q) begin
      hi_q <= {sum[DIFF_W], sum[DIFF_W:1]};
      lo_q <= {sum[0], lo_q[ALPHA_W-1:1]};
      mp_q <= {1'b0, mp_q[ALPHA_W-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = {hi_q, lo_q};

endmodule

`default_nettype wire

### hdl/variable_step_low_pass_filter.sv
// Variable-step first-order low-pass filter.
// Input channel: in_valid_i/in_ready_o carry one word with a signed sample and its
// free-running tick timestamp. Output channel: out_valid_o/out_ready_i carry one
// word per input with the rounded filtered value and a restart flag.
// Configuration channel: cfg_valid_i/cfg_ready_o write time_const (index 0) or
// gap_limit (index 1); it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. A filtered word passes from
// acceptance, which registers the sample and the gap, to the prepare step, which
// loads the divider; the bit-serial divider forms the weight, its done loads the
// bit-serial multiplier, which forms the update, and the final step rounds the
// result into the output register. A restart word (first sample after reset, or gap
// above gap_limit) goes from acceptance straight to the final step. One word is in
// work at a time; the next is accepted the cycle after the result enters the output
// register, even while the receiver has not taken it. When the receiver stalls, the
// finished word waits in the final step until the output register is free. Reset
// clears the stored value, the last timestamp and the primed flag, and restores the
// configuration defaults.
`default_nettype none
`include "assert_macros.svh"

module variable_step_low_pass_filter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  vslpf_pkg::vslpf_in_t             in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output vslpf_pkg::vslpf_out_t            out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [vslpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [vslpf_pkg::CFG_W-1:0]      cfg_data_i
);
  import vslpf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CFG_W-1:0]        tc_q, gap_q;
  logic [ACC_W-1:0]        smoothed_q;
  logic [TIME_WIDTH-1:0]   last_stamp_q;
  logic                    primed_q;
  logic [SAMPLE_WIDTH-1:0] x_q;
  logic                    rs_q;
  logic [CFG_W-1:0]        d_q;
  logic                    out_valid_q;
  vslpf_out_t              out_q;

  logic                    in_acc;
  logic [TIME_WIDTH-1:0]   d_full;
  logic                    rs;
  logic                    div_start, mul_start, fin_load;
  vslpf_stat_t             div_stat, mul_stat;
  logic [ALPHA_W-1:0]      div_quot, alpha, weight;
  logic [DVS_W-1:0]        divisor;
  logic [ACC_W-1:0]        xs;
  logic [DIFF_W-1:0]       diff;
  logic [PROD_W-1:0]       prod;
  logic [PART_W-1:0]       part, sm_sum;
  logic [ACC_W-1:0]        sm_new;
  logic [SAMPLE_WIDTH-1:0] y;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign d_full = in_data_i.stamp - last_stamp_q;
  assign rs     = !primed_q || (d_full > TIME_WIDTH'(gap_q));

  assign div_start = (state_q == ST_PREP);
  assign divisor   = DVS_W'(tc_q) + DVS_W'(d_q);
  assign mul_start = (state_q == ST_DIV) && div_stat.done;
  assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign alpha  = (tc_q == '0) ? '0 : div_quot;
  assign weight = (ALPHA_W'(1) << FRAC_BITS) - alpha;
  assign xs     = {x_q, {FRAC_BITS{1'b0}}};
  assign diff   = {xs[ACC_W-1], xs} - {smoothed_q[ACC_W-1], smoothed_q};

  // Round half up: add the bit just below the binary point.
  assign part   = prod[PROD_W-1:FRAC_BITS] + PART_W'(prod[FRAC_BITS-1]);
  assign sm_sum = {{(PART_W-ACC_W){smoothed_q[ACC_W-1]}}, smoothed_q} + part;
  assign sm_new = sm_sum[ACC_W-1:0];
  assign y      = sm_new[ACC_W-1:FRAC_BITS] + SAMPLE_WIDTH'(sm_new[FRAC_BITS-1]);

  vslpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tc_q),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  vslpf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (diff),
    .mplier_i (weight),
    .stat_o   (mul_stat),
    .prod_o   (prod)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = rs ? ST_FIN : ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_MUL;
      ST_MUL:  if (mul_stat.done) state_d = ST_FIN;
      ST_FIN:  if (fin_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tc_q         <= TIME_CONST_RST;
      gap_q        <= GAP_LIMIT_RST;
      smoothed_q   <= '0;
      last_stamp_q <= '0;
      primed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_TIME_CONST: tc_q  <= cfg_data_i;
          CFG_GAP_LIMIT:  gap_q <= cfg_data_i;
          default:        tc_q  <= tc_q;
        endcase
      end
      if (in_acc) begin
        last_stamp_q <= in_data_i.stamp;
        primed_q     <= 1'b1;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
        smoothed_q  <= rs_q ? xs : sm_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= in_data_i.sample;
      rs_q <= rs;
      d_q  <= d_full[CFG_W-1:0];
    end
    if (fin_load) begin
      out_q.filtered  <= rs_q ? x_q : y;
      out_q.restarted <= rs_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_o, "accepted while busy")
  `ASSERT_IMPLY(a_units_exclusive, clk_i, rst_ni, div_stat.busy, !mul_stat.busy, "units overlap")
  `ASSERT_IMPLY(a_mul_done_state, clk_i, rst_ni, mul_stat.done, state_q == ST_MUL, "stray done")
  `ASSERT_IMPLY(a_idle_quiet, clk_i, rst_ni, state_q == ST_IDLE,
                !div_stat.busy && !mul_stat.busy, "unit busy in idle")

endmodule

`default_nettype wire

### dv/tb_variable_step_low_pass_filter.sv
module tb_variable_step_low_pass_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import vslpf_pkg::*;

  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint SMAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct packed {
    bit                   cfg_row;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    vslpf_in_t            word;
    bit                   typed;
    vslpf_out_t           want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  vslpf_in_t            in_data = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  vslpf_out_t           out_data_o;
  logic                 cfg_ready_o;

  longint               acc_q = 0;
  logic [TIME_WIDTH-1:0] prev_stamp = '0;
  bit                   seen = 1'b0;
  logic [CFG_W-1:0]     tc_reg = TIME_CONST_RST;
  logic [CFG_W-1:0]     gl_reg = GAP_LIMIT_RST;

  vslpf_out_t           filtered_q[$];
  plan_row_t            plan_q[$];
  bit                   calm = 1'b0;
  int                   stall_left = 0;
  int                   fail_count = 0;
  int                   words_sent = 0;
  int                   result_count = 0;
  int                   restart_count = 0;
  int                   cfg_writes = 0;

  variable_step_low_pass_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic vslpf_out_t filter_step(input vslpf_in_t w);
    logic [TIME_WIDTH-1:0] gap;
    longint unsigned num;
    longint unsigned den;
    longint xs;
    longint alpha;
    longint wt;
    longint diff;
    longint hi;
    longint lo;
    longint part;
    longint y;
    bit rs;
    vslpf_out_t r;
    gap = w.stamp - prev_stamp;
    xs = longint'($signed(w.sample)) * ONE;
    rs = !seen || (gap > gl_reg);
    prev_stamp = w.stamp;
    seen = 1'b1;
    if (rs) begin
      acc_q = xs;
      r.filtered = w.sample;
    end else begin
      if (tc_reg == '0) begin
        alpha = 0;
      end else begin
        num = longint'(tc_reg) << FRAC_BITS;
        den = longint'(tc_reg) + longint'(gap);
        alpha = longint'(num / den);
      end
      wt = ONE - alpha;
      diff = xs - acc_q;
      hi = diff >>> FRAC_BITS;
      lo = diff - hi * ONE;
      part = wt * hi + ((wt * lo + (ONE >>> 1)) >>> FRAC_BITS);
      acc_q = acc_q + part;
      y = (acc_q + (ONE >>> 1)) >>> FRAC_BITS;
      if (y > SMAX) begin
        y = SMAX;
      end
      if (y < SMIN) begin
        y = SMIN;
      end
      r.filtered = y[SAMPLE_WIDTH-1:0];
    end
    r.restarted = rs;
    return r;
  endfunction

  task automatic push_word(input vslpf_in_t w, input bit typed, input vslpf_out_t want);
    int unsigned idle;
    vslpf_out_t got;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      idle = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk_i); while (!in_ready_o);
    got = filter_step(w);
    filtered_q.push_back(typed ? want : got);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TIME_CONST) begin
      tc_reg = val;
    end else if (idx == CFG_GAP_LIMIT) begin
      gl_reg = val;
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic plan_word(input logic signed [SAMPLE_WIDTH-1:0] s,
                           input logic [TIME_WIDTH-1:0] st, input bit typed,
                           input logic signed [SAMPLE_WIDTH-1:0] f, input bit rs);
    plan_row_t row;
    row = '0;
    row.word.sample = s;
    row.word.stamp = st;
    row.typed = typed;
    row.want.filtered = f;
    row.want.restarted = rs;
    plan_q.push_back(row);
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.cfg_row = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan_q.push_back(row);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vslpf_out_t exp_word;
    if (rst_ni && out_valid_o && out_ready) begin
      result_count++;
      if (out_data_o.restarted) begin
        restart_count++;
      end
      if (filtered_q.size() == 0) begin
        $error("output word with nothing expected: filtered %0d restarted %0b",
               out_data_o.filtered, out_data_o.restarted);
        fail_count++;
      end else begin
        exp_word = filtered_q.pop_front();
        if (out_data_o.filtered !== exp_word.filtered) begin
          $error("filtered: expected %0d, got %0d", exp_word.filtered, out_data_o.filtered);
          fail_count++;
        end
        if (out_data_o.restarted !== exp_word.restarted) begin
          $error("restarted: expected %0b, got %0b", exp_word.restarted,
                 out_data_o.restarted);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] tc_v;
    logic [CFG_W-1:0] gl_v;
    logic [TIME_WIDTH-1:0] stamp_now;
    logic [TIME_WIDTH-1:0] gap_v;
    logic signed [SAMPLE_WIDTH-1:0] last_sample;
    vslpf_in_t w;
    int walk;
    int unsigned pick;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    plan_word(16'sd32767, 32'd100, 1'b1, 16'sd32767, 1'b1);
    plan_word(-16'sd32768, 32'd100, 1'b1, 16'sd32767, 1'b0);
    plan_word(-16'sd32768, 32'd6101, 1'b1, -16'sd32768, 1'b1);
    plan_word(16'sd32767, 32'd12101, 1'b0, 16'sd0, 1'b0);
    plan_word(16'sd0, 32'd12102, 1'b0, 16'sd0, 1'b0);
    plan_word(-16'sd1, 32'd12103, 1'b0, 16'sd0, 1'b0);
    plan_word(16'sd1234, 32'd50, 1'b1, 16'sd1234, 1'b1);
    plan_word(-16'sd1, 32'hFFFF_FFF0, 1'b1, -16'sd1, 1'b1);
    plan_word(16'sd32767, 32'h0000_0010, 1'b0, 16'sd0, 1'b0);
    plan_word(16'sd32767, 32'h0000_0020, 1'b0, 16'sd0, 1'b0);
    plan_word(-16'sd32768, 32'h0000_0030, 1'b0, 16'sd0, 1'b0);
    plan_cfg(CFG_TIME_CONST, 16'd0);
    plan_word(-16'sd32768, 32'h0000_0040, 1'b1, -16'sd32768, 1'b0);
    plan_word(16'sd32767, 32'h0000_0040, 1'b1, 16'sd32767, 1'b0);
    plan_cfg(CFG_TIME_CONST, 16'd65535);
    plan_cfg(CFG_GAP_LIMIT, 16'd0);
    plan_word(-16'sd32768, 32'h0000_0040, 1'b1, 16'sd32767, 1'b0);
    plan_word(16'sd100, 32'h0000_0041, 1'b1, 16'sd100, 1'b1);
    plan_cfg(CFG_GAP_LIMIT, 16'd65535);
    plan_word(-16'sd32768, 32'h0001_0040, 1'b0, 16'sd0, 1'b0);
    plan_word(16'sd7, 32'hFFFF_FFFF, 1'b1, 16'sd7, 1'b1);
    plan_word(-16'sd7, 32'hFFFF_FFFF, 1'b1, 16'sd7, 1'b0);
    plan_cfg(CFG_TIME_CONST, 16'd1);
    plan_word(-16'sd32768, 32'h0000_0000, 1'b0, 16'sd0, 1'b0);
    plan_word(16'sd32767, 32'h0000_FFFF, 1'b0, 16'sd0, 1'b0);

    foreach (plan_q[i]) begin
      if (plan_q[i].cfg_row) begin
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        push_word(plan_q[i].word, plan_q[i].typed, plan_q[i].want);
      end
    end

    stamp_now = 32'hFFFF;
    last_sample = 16'sd7;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          tc_v = 16'd500;
          gl_v = 16'd6000;
        end
        1: begin
          tc_v = 16'd1;
          gl_v = 16'd0;
        end
        2: begin
          tc_v = 16'd65535;
          gl_v = 16'd65535;
        end
        3: begin
          tc_v = 16'd0;
          gl_v = 16'd3000;
        end
        6: begin
          tc_v = 16'd2000;
          gl_v = 16'd20000;
        end
        default: begin
          tc_v = CFG_W'($urandom_range(1, 65535));
          gl_v = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CFG_TIME_CONST, tc_v);
      write_reg(CFG_GAP_LIMIT, gl_v);
      calm = (p == 6);
      if (p % 2 == 1) begin
        stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end else begin
        stamp_now = $urandom;
      end
      for (int k = 0; k < 125; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          w.sample = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        end else if (pick < 4) begin
          w.sample = SAMPLE_WIDTH'($urandom);
        end else begin
          walk = last_sample + int'($urandom_range(0, 512)) - 256;
          if (walk > 32767) begin
            walk = 32767;
          end
          if (walk < -32768) begin
            walk = -32768;
          end
          w.sample = walk[SAMPLE_WIDTH-1:0];
        end
        last_sample = w.sample;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          gap_v = '0;
        end else if (pick == 1) begin
          gap_v = gl_v;
        end else if (pick == 2) begin
          gap_v = gl_v + 1 + $urandom_range(0, 100000);
        end else if (pick < 8) begin
          gap_v = $urandom_range(0, 16);
        end else begin
          gap_v = $urandom_range(0, gl_v);
        end
        if (pick == 3) begin
          stamp_now = $urandom;
        end else begin
          stamp_now = stamp_now + gap_v;
        end
        w.stamp = stamp_now;
        push_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d input words and %0d results (%0d restarts)",
             words_sent, result_count, restart_count);
    $display("over %0d register writes.", cfg_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/vslpf_pkg.sv
hdl/vslpf_div.sv
hdl/vslpf_mul.sv
hdl/variable_step_low_pass_filter.sv
dv/tb_variable_step_low_pass_filter.sv
